### rtl/glyph_row_rasterizer_assert.svh
// assertion macros shared by the rasterizer modules
`ifndef GLYPH_ROW_RASTERIZER_ASSERT_SVH
`define GLYPH_ROW_RASTERIZER_ASSERT_SVH
`ifndef SYNTH
`define GRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GRR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRR_ASSERT(lbl, prop, msg)
`define GRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/grr_pkg.sv
package grr_pkg;

	localparam int PANEL_WIDTH  = 16;
	localparam int PANEL_HEIGHT = 16;
	localparam int MAX_SLOTS    = PANEL_WIDTH / 4 + 1;
	localparam int SLOT_W       = 3;
	localparam int GLYPH_COUNT  = 87;
	localparam int GLYPH_AW     = 7;
	localparam int GLYPH_W      = 32;

	localparam logic [GLYPH_AW-1:0] GLYPH_DIGIT = 7'd0;
	localparam logic [GLYPH_AW-1:0] GLYPH_BLANK = 7'd10;
	localparam logic [GLYPH_AW-1:0] GLYPH_UPPER = 7'd11;
	localparam logic [GLYPH_AW-1:0] GLYPH_PUNCT = 7'd37;
	localparam logic [GLYPH_AW-1:0] GLYPH_LOWER = 7'd61;

	localparam logic REG_X_OFFSET = 1'b0;
	localparam logic REG_Y_OFFSET = 1'b1;

	// row r of a glyph sits in bits [4r+3:4r], msb is the leftmost column
	localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		32'h02555520, 32'h07222620, 32'h07421520, 32'h06116160, 32'h01117550,
		32'h06117470, 32'h02556470, 32'h01111170, 32'h02552520, 32'h01113520,
		32'h00000000,
		32'h05557570, 32'h06556560, 32'h07444470, 32'h06555560, 32'h07447470,
		32'h04447470, 32'h07554470, 32'h05557550, 32'h07222270, 32'h06222270,
		32'h05556550, 32'h07444440, 32'h05557750, 32'h05555570, 32'h07555570,
		32'h04447570, 32'h07775570, 32'h05556570, 32'h07117470, 32'h02222270,
		32'h07555550, 32'h02555550, 32'h07775550, 32'h05552550, 32'h02225550,
		32'h07447170,
		32'h02000000, 32'h42000000, 32'h00007000, 32'h04422110, 32'h00202000,
		32'h04202000, 32'h02636320, 32'h02444420, 32'h02111120, 32'h06444460,
		32'h03111130, 32'h01226210, 32'h04223240, 32'h07000000, 32'h00027200,
		32'h05F5F500, 32'h00000220, 32'h00000550, 32'h02022220, 32'h02021160,
		32'h00024200, 32'h00021200, 32'h00052500, 32'h05421500,
		32'h03530000, 32'h06564440, 32'h03430000, 32'h03531110, 32'h03475200,
		32'h04464300, 32'h06135300, 32'h05574440, 32'h02220200, 32'h06111010,
		32'h05654440, 32'h01222220, 32'h05575000, 32'h05556000, 32'h02552000,
		32'h04446560, 32'h01113530, 32'h04447000, 32'h06124300, 32'h02446400,
		32'h03555000, 32'h02555000, 32'h07755000, 32'h05255000, 32'h06113550,
		32'h07421700
	};

	typedef struct packed {
		logic signed [6:0] left;
		logic [3:0]        y0;
		logic [2:0]        last_r;
	} desc_t;

	typedef struct packed {
		logic                we;
		logic [GLYPH_AW-1:0] waddr;
		logic [GLYPH_W-1:0]  wdata;
		logic                re;
		logic [GLYPH_AW-1:0] raddr;
	} ram_req_t;

	function automatic logic [GLYPH_W-1:0] glyph_rom_f(input logic [GLYPH_AW-1:0] idx);
		return GLYPH_ROM[idx];
	endfunction

	function automatic logic [GLYPH_AW-1:0] glyph_of_f(input logic [6:0] c);
		logic [GLYPH_AW-1:0] g;
		g = GLYPH_BLANK;
		priority if (c >= 7'("0") && c <= 7'("9")) begin
			g = GLYPH_DIGIT + (c - 7'("0"));
		end else if (c >= 7'("A") && c <= 7'("Z")) begin
			g = GLYPH_UPPER + (c - 7'("A"));
		end else if (c >= 7'("a") && c <= 7'("z")) begin
			g = GLYPH_LOWER + (c - 7'("a"));
		end else begin
			case (c)
				7'("."):  g = GLYPH_PUNCT + 7'd0;
				7'(","):  g = GLYPH_PUNCT + 7'd1;
				7'("-"):  g = GLYPH_PUNCT + 7'd2;
				7'("/"):  g = GLYPH_PUNCT + 7'd3;
				7'(":"):  g = GLYPH_PUNCT + 7'd4;
				7'(";"):  g = GLYPH_PUNCT + 7'd5;
				7'("$"):  g = GLYPH_PUNCT + 7'd6;
				7'("("):  g = GLYPH_PUNCT + 7'd7;
				7'(")"):  g = GLYPH_PUNCT + 7'd8;
				7'("["):  g = GLYPH_PUNCT + 7'd9;
				7'("]"):  g = GLYPH_PUNCT + 7'd10;
				7'("{"):  g = GLYPH_PUNCT + 7'd11;
				7'("}"):  g = GLYPH_PUNCT + 7'd12;
				7'("_"):  g = GLYPH_PUNCT + 7'd13;
				7'("+"):  g = GLYPH_PUNCT + 7'd14;
				7'("#"):  g = GLYPH_PUNCT + 7'd15;
				7'("'"):  g = GLYPH_PUNCT + 7'd16;
				7'("\""): g = GLYPH_PUNCT + 7'd17;
				7'("!"):  g = GLYPH_PUNCT + 7'd18;
				7'("?"):  g = GLYPH_PUNCT + 7'd19;
				7'("<"):  g = GLYPH_PUNCT + 7'd20;
				7'(">"):  g = GLYPH_PUNCT + 7'd21;
				7'("*"):  g = GLYPH_PUNCT + 7'd22;
				7'("%"):  g = GLYPH_PUNCT + 7'd23;
				default:  g = GLYPH_BLANK;
			endcase
		end
		return g;
	endfunction

endpackage

### rtl/grr_ram.sv
module grr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/grr_front.sv
`include "glyph_row_rasterizer_assert.svh"

module grr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tuser,
	input  logic [4:0]       x_offset,
	input  logic [3:0]       y_offset,
	input  logic             move,
	output logic             vld_s1,
	output grr_pkg::desc_t   desc_s1,
	output grr_pkg::ram_req_t ram_req
);

	import grr_pkg::*;

	logic                filling_q;
	logic [GLYPH_AW-1:0] fill_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                vld_s1_q;
	desc_t               desc_s1_q;

	logic              accept;
	logic              emit;
	logic              in_range;
	logic [SLOT_W-1:0] slot_cur;
	logic [4:0]        y_sum;
	desc_t             desc_new;

	always_comb begin
		slot_cur        = s_tuser ? '0 : slot_q;
		in_range        = slot_cur < SLOT_W'(MAX_SLOTS);
		y_sum           = {1'b0, y_offset} + 5'd8;
		emit            = in_range && ({1'b0, y_offset} < 5'(PANEL_HEIGHT));
		desc_new.left   = $signed({{2{x_offset[4]}}, x_offset})
		                + $signed({2'b00, slot_cur, 2'b00});
		desc_new.y0     = y_offset;
		desc_new.last_r = (y_sum > 5'(PANEL_HEIGHT))
		                ? 3'(5'(PANEL_HEIGHT) - 5'd1 - {1'b0, y_offset}) : 3'd7;
		s_tready        = !filling_q && (!vld_s1_q || move);
		accept          = s_tvalid && s_tready;
	end

	always_comb begin
		ram_req.we    = filling_q;
		ram_req.waddr = fill_q;
		ram_req.wdata = glyph_rom_f(fill_q);
		ram_req.re    = accept && emit;
		ram_req.raddr = glyph_of_f(s_tdata[6:0]);
	end

	// glyph store load after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filling_q <= 1'b1;
			fill_q    <= '0;
		end else if (filling_q) begin
			if (fill_q == GLYPH_AW'(GLYPH_COUNT - 1)) begin
				filling_q <= 1'b0;
			end
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			vld_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				slot_q <= in_range ? slot_cur + 1'b1 : slot_cur;
			end
			if (accept && emit) begin
				vld_s1_q <= 1'b1;
			end else if (move) begin
				vld_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			desc_s1_q <= desc_new;
		end
	end

	assign vld_s1  = vld_s1_q;
	assign desc_s1 = desc_s1_q;

	`GRR_ASSERT_ALWAYS(a_fill_blocks_input, filling_q |-> !s_tready, "word accepted during load")
	`GRR_ASSERT(a_slot_saturates, slot_q <= SLOT_W'(MAX_SLOTS), "slot beyond last")
	`GRR_ASSERT(a_s1_holds, (vld_s1_q && !move) |=> vld_s1_q, "pending character lost")

endmodule

### rtl/grr_row.sv
`include "glyph_row_rasterizer_assert.svh"

module grr_row (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_s1,
	input  grr_pkg::desc_t               desc_s1,
	input  logic [grr_pkg::GLYPH_W-1:0]  glyph,
	output logic                         move,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,
	output logic                         m_tlast
);

	import grr_pkg::*;

	logic               act_s2_q;
	logic [2:0]         r_s2_q;
	desc_t              desc_s2_q;
	logic [GLYPH_W-1:0] glyph_s2_q;

	logic        out_vld_q;
	logic [3:0]  out_row_q;
	logic [15:0] out_pix_q;
	logic        out_last_q;

	logic              step;
	logic              done;
	logic [3:0]        bits;
	logic [15:0]       mask;
	logic signed [7:0] d;

	always_comb begin
		step = act_s2_q && (!out_vld_q || m_tready);
		done = step && (r_s2_q == desc_s2_q.last_r);
		move = vld_s1 && (!act_s2_q || done);
		bits = glyph_s2_q[{r_s2_q, 2'b00} +: 4];
	end

	always_comb begin
		mask = '0;
		d    = '0;
		for (int c = 0; c < 16; c++) begin
			d = $signed(8'(c)) - $signed({desc_s2_q.left[6], desc_s2_q.left});
			mask[c] = (c < PANEL_WIDTH) && !d[7] && (d < 8'sd4) && bits[2'd3 - d[1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2_q  <= 1'b0;
			r_s2_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (move) begin
				act_s2_q <= 1'b1;
				r_s2_q   <= '0;
			end else if (done) begin
				act_s2_q <= 1'b0;
			end else if (step) begin
				r_s2_q <= r_s2_q + 1'b1;
			end
			if (step) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			desc_s2_q  <= desc_s1;
			glyph_s2_q <= glyph;
		end
		if (step) begin
			out_row_q  <= desc_s2_q.y0 + {1'b0, r_s2_q};
			out_pix_q  <= mask;
			out_last_q <= (r_s2_q == desc_s2_q.last_r);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_pix_q, out_row_q};
	assign m_tlast  = out_last_q;

	`GRR_ASSERT(a_row_in_range, act_s2_q |-> (r_s2_q <= desc_s2_q.last_r), "row past end")
	`GRR_ASSERT(a_idle_drains, (m_tvalid && m_tready && !act_s2_q) |=> !m_tvalid, "stray word")
	`GRR_ASSERT(a_out_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "word changed")

endmodule

### rtl/glyph_row_rasterizer.sv
// glyph row rasterizer: 4x8 text glyphs onto a 16x16 one-colour panel
// input channel s_*: one character per word, s_tuser marks the first of a message
// output channel m_*: one word per glyph row kept on the panel, m_tlast on the
// final row of a character; a character past the last slot gives no word
// apb port: x_offset at 0x0 (signed 5 bits), y_offset at 0x4 (4 bits)
// path: the holding stage and glyph store read, then the row sequencer, then the output register
// throughput: one row word per cycle while m_tready is high; the row
// sequencer, one glyph store read per character, sets this rate
// a character waits in a single holding stage while the previous one drains
// reset: the glyph store is loaded from the constant table with s_tready
// low; offsets and slot position clear to zero
// stall: when m_tready is low a pending output word holds and the row sequencer
// stops; s_tready drops while the holding stage is full and cannot move on
module glyph_row_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tuser,   // first_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // row_index, row_pixels, zero fill
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import grr_pkg::*;

	logic [4:0] x_offset_q;
	logic [3:0] y_offset_q;

	logic               move;
	logic               vld_s1;
	desc_t              desc_s1;
	ram_req_t           ram_req;
	logic [GLYPH_W-1:0] glyph;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
			y_offset_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_X_OFFSET: x_offset_q <= pwdata[4:0];
				REG_Y_OFFSET: y_offset_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_X_OFFSET: prdata = {27'b0, x_offset_q};
			REG_Y_OFFSET: prdata = {28'b0, y_offset_q};
		endcase
	end

	grr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.x_offset (x_offset_q),
		.y_offset (y_offset_q),
		.move     (move),
		.vld_s1   (vld_s1),
		.desc_s1  (desc_s1),
		.ram_req  (ram_req)
	);

	grr_ram #(
		.WIDTH (GLYPH_W),
		.DEPTH (GLYPH_COUNT)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (glyph)
	);

	grr_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.desc_s1  (desc_s1),
		.glyph    (glyph),
		.move     (move),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
